/* hdl/rlew_pkg.sv */
// Shared types and constants for the RLEW word run decoder.
package rlew_pkg;

  localparam logic [15:0] MarkerReset = 16'hFEFE;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhWord   = 4'b0010,
    PhCount  = 4'b0100,
    PhValue  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] length;
    logic        done;
  } run_t;

endpackage

/* hdl/rlew_front.sv */
// Front end: parses header, marker, count and value words into run records.
module rlew_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              marker_we_i,
  input  logic [15:0]       marker_wdata_i,
  input  logic              word_valid_i,
  input  logic [15:0]       word_i,
  output logic              run_valid_o,
  output rlew_pkg::run_t    run_o
);

  rlew_pkg::phase_e phase_q, phase_d;
  logic [15:0] marker_q;
  logic [15:0] target_q, target_d;
  logic [16:0] total_q, total_d;
  logic [15:0] count_q, count_d;

  logic [15:0] run_count;
  logic [16:0] sum;
  logic        done;

  // The run length is one for a literal and the stored count for a triple.
  assign run_count = (phase_q == rlew_pkg::PhValue) ? count_q : 16'd1;
  assign sum       = total_q + {1'b0, run_count};
  assign done      = (sum >= {1'b0, target_q});

  always_comb begin
    phase_d     = phase_q;
    target_d    = target_q;
    total_d     = total_q;
    count_d     = count_q;
    run_valid_o = 1'b0;
    run_o.value  = word_i;
    run_o.length = run_count;
    run_o.done   = done;
    if (word_valid_i) begin
      unique case (phase_q)
        rlew_pkg::PhHeader: begin
          target_d = word_i;
          total_d  = '0;
          count_d  = '0;
          phase_d  = (word_i == 16'd0) ? rlew_pkg::PhHeader : rlew_pkg::PhWord;
        end
        rlew_pkg::PhWord: begin
          if (word_i == marker_q) begin
            phase_d = rlew_pkg::PhCount;
          end else begin
            run_valid_o = 1'b1;
            total_d     = sum;
            phase_d     = done ? rlew_pkg::PhHeader : rlew_pkg::PhWord;
          end
        end
        rlew_pkg::PhCount: begin
          count_d = word_i;
          phase_d = rlew_pkg::PhValue;
        end
        rlew_pkg::PhValue: begin
          if (count_q == 16'd0) begin
            phase_d = rlew_pkg::PhWord;
          end else begin
            run_valid_o = 1'b1;
            total_d     = sum;
            phase_d     = done ? rlew_pkg::PhHeader : rlew_pkg::PhWord;
          end
        end
        default: begin
          phase_d = rlew_pkg::PhHeader;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rlew_pkg::PhHeader;
      marker_q <= rlew_pkg::MarkerReset;
      target_q <= '0;
      total_q  <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      target_q <= target_d;
      total_q  <= total_d;
      count_q  <= count_d;
      if (marker_we_i) begin
        marker_q <= marker_wdata_i;
      end
    end
  end

endmodule

/* hdl/rlew_queue.sv */
// Back end: run record queue that holds results until the consumer takes them.
module rlew_queue #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  rlew_pkg::run_t  wr_data_i,
  input  logic            rd_i,
  output rlew_pkg::run_t  rd_data_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  rlew_pkg::run_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/rlew_word_run_decoder_unit.sv */
// RLEW word run decoder: takes one code word per cycle unless full, delivers one run per transfer.
// A run is registered in the run queue and reaches the result ports once earlier runs are popped.
// Throughput: one code word per cycle; the run queue of QueueDepth entries absorbs result stalls,
// and push is refused only while that queue is full.
// Reset: asynchronous, active low; clears the parser to wait for a header, the marker to 0xFEFE,
// and empties the run queue.
module rlew_word_run_decoder_unit #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        marker_we_i,
  input  logic [15:0] marker_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] run_value_o,
  output logic [15:0] run_length_o,
  output logic        stream_done_o
);

  logic           word_valid;
  logic           run_valid;
  rlew_pkg::run_t run;
  rlew_pkg::run_t head;

  // A word transfer only happens while the queue can take any run it produces.
  assign word_valid = push && !full;

  rlew_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .marker_we_i    (marker_we_i),
    .marker_wdata_i (marker_wdata_i),
    .word_valid_i   (word_valid),
    .word_i         (code_word_i),
    .run_valid_o    (run_valid),
    .run_o          (run)
  );

  rlew_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (run_valid),
    .wr_data_i (run),
    .rd_i      (pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  assign run_value_o   = head.value;
  assign run_length_o  = head.length;
  assign stream_done_o = head.done;

endmodule

/* tb/rlew_word_run_decoder_unit_tb.sv */
// Self-checking testbench for the RLEW word run decoder unit.
`timescale 1ns / 1ps

module rlew_word_run_decoder_unit_tb;

  localparam int ResetCycles = 11;
  localparam int RandomWords = 1300;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 4;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        marker_we_i    = 1'b0;
  logic [15:0] marker_wdata_i = '0;
  logic        push           = 1'b0;
  logic        full;
  logic [15:0] code_word_i    = '0;
  logic        empty;
  logic        pop            = 1'b0;
  logic [15:0] run_value_o;
  logic [15:0] run_length_o;
  logic        stream_done_o;

  // Shadow copy of the decoder state.
  rlew_pkg::phase_e dec_phase;
  logic [15:0] dec_marker;
  logic [15:0] dec_target;
  logic [16:0] dec_total;
  logic [15:0] dec_count;

  rlew_pkg::run_t expected_runs[$];

  bit          push_idle_on = 1'b1;
  bit          pop_idle_on  = 1'b1;
  int          error_count  = 0;
  int          words_sent   = 0;
  int          runs_checked = 0;
  int          streams_done = 0;
  int          marker_writes = 0;
  int          quiet_cycles = 0;

  rlew_word_run_decoder_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .marker_we_i    (marker_we_i),
    .marker_wdata_i (marker_wdata_i),
    .push           (push),
    .full           (full),
    .code_word_i    (code_word_i),
    .empty          (empty),
    .pop            (pop),
    .run_value_o    (run_value_o),
    .run_length_o   (run_length_o),
    .stream_done_o  (stream_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic finish_run(input logic [15:0] value, input logic [15:0] count);
    rlew_pkg::run_t run;
    dec_total  = dec_total + {1'b0, count};
    run.value  = value;
    run.length = count;
    run.done   = (dec_total >= {1'b0, dec_target});
    expected_runs.insert(expected_runs.size(), run);
    dec_phase  = run.done ? rlew_pkg::PhHeader : rlew_pkg::PhWord;
  endtask

  // Advances the shadow parser by one code word.
  task automatic decode_word(input logic [15:0] w);
    case (dec_phase)
      rlew_pkg::PhHeader: begin
        dec_target = w;
        dec_total  = '0;
        dec_count  = '0;
        dec_phase  = (w == 16'h0000) ? rlew_pkg::PhHeader : rlew_pkg::PhWord;
      end
      rlew_pkg::PhWord: begin
        if (w == dec_marker) dec_phase = rlew_pkg::PhCount;
        else finish_run(w, 16'd1);
      end
      rlew_pkg::PhCount: begin
        dec_count = w;
        dec_phase = rlew_pkg::PhValue;
      end
      default: begin
        if (dec_count == 16'h0000) dec_phase = rlew_pkg::PhWord;
        else finish_run(w, dec_count);
      end
    endcase
  endtask

  task automatic send_word(input logic [15:0] w);
    int unsigned gap;
    gap = push_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk_i) push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push        <= 1'b1;
    code_word_i <= w;
    do @(posedge clk_i); while (full);
    decode_word(w);
    words_sent++;
  endtask

  // Lowers push and waits until every predicted run has been taken.
  task automatic wait_idle();
    @(negedge clk_i) push <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [15:0] value);
    wait_idle();
    @(negedge clk_i);
    marker_we_i    <= 1'b1;
    marker_wdata_i <= value;
    @(negedge clk_i) marker_we_i <= 1'b0;
    dec_marker = value;
    marker_writes++;
  endtask

  function automatic logic [15:0] pick_marker();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return rlew_pkg::MarkerReset;
      default: return 16'($urandom());
    endcase
  endfunction

  // One well-formed stream with random content; follows the shadow parser to its end.
  task automatic send_stream();
    logic [15:0] len;
    int          pick;
    int          n;
    pick = $urandom_range(0, 99);
    if (pick < 5) len = 16'h0000;
    else if (pick < 85) len = 16'($urandom_range(1, 12));
    else if (pick < 97) len = 16'($urandom_range(13, 80));
    else len = 16'($urandom_range(81, 65535));
    send_word(len);
    n = 0;
    while (dec_phase != rlew_pkg::PhHeader) begin
      case (dec_phase)
        rlew_pkg::PhWord: begin
          if ($urandom_range(0, 3) == 0) send_word(dec_marker);
          else send_word(16'($urandom()));
        end
        rlew_pkg::PhCount: begin
          // Long streams are closed quickly with the largest count.
          pick = $urandom_range(0, 99);
          if (n > 60 || pick < 5) send_word(16'hFFFF);
          else if (pick < 15) send_word(16'h0000);
          else send_word(16'($urandom_range(1, 6)));
        end
        default: send_word(16'($urandom()));
      endcase
      n++;
      if (dec_phase == rlew_pkg::PhWord && $urandom_range(0, 99) == 0) begin
        write_marker(pick_marker());
      end
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) send_word(dec_marker);
      else send_word(16'($urandom()));
    end
  endtask

  task automatic test_reset_marker_stream();
    send_word(16'd3);
    send_word(16'h0000);
    send_word(rlew_pkg::MarkerReset);
    send_word(16'd2);
    send_word(16'hFFFF);
  endtask

  task automatic test_empty_and_marker_header();
    send_word(16'h0000);
    // The marker value in header position is a length.
    send_word(rlew_pkg::MarkerReset);
    send_word(rlew_pkg::MarkerReset);
    send_word(16'hFFFF);
    send_word(16'h1234);
  endtask

  task automatic test_overshoot();
    send_word(16'd2);
    send_word(16'h00FF);
    send_word(rlew_pkg::MarkerReset);
    send_word(16'hFFFF);
    send_word(16'h8000);
  endtask

  task automatic test_zero_count();
    write_marker(16'hFFFF);
    send_word(16'd2);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h0007);
    send_word(16'h0000);
    send_word(16'hFFFE);
  endtask

  task automatic test_marker_change_mid_stream();
    send_word(16'd4);
    send_word(16'h1111);
    write_marker(16'h0000);
    send_word(16'h0000);
    send_word(16'd3);
    send_word(16'hABCD);
  endtask

  task automatic test_random_streams();
    int start;
    start = words_sent;
    while (words_sent - start < RandomWords) begin
      if ($urandom_range(0, 7) == 0) begin
        push_idle_on = $urandom_range(0, 2) != 0;
        pop_idle_on  = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 9) == 0) write_marker(pick_marker());
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_stream();
    end
  endtask

  // Result side: random pop stalls, pop stays high across back-to-back transfers.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = pop_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        @(negedge clk_i) pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    rlew_pkg::run_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_runs.size() == 0) begin
        report_error($sformatf("unexpected run value %h length %h done %b",
                               run_value_o, run_length_o, stream_done_o));
      end else begin
        want = expected_runs.pop_front();
        if (run_value_o !== want.value)
          report_error($sformatf("run_value %h expected %h", run_value_o, want.value));
        if (run_length_o !== want.length)
          report_error($sformatf("run_length %h expected %h", run_length_o, want.length));
        if (stream_done_o !== want.done)
          report_error($sformatf("stream_done %b expected %b", stream_done_o, want.done));
        runs_checked++;
        if (want.done) streams_done++;
      end
    end
  end

  // Watchdog on cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without a transfer", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dec_phase  = rlew_pkg::PhHeader;
    dec_marker = rlew_pkg::MarkerReset;
    dec_target = '0;
    dec_total  = '0;
    dec_count  = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_marker_stream();
    test_empty_and_marker_header();
    test_overshoot();
    test_zero_count();
    test_marker_change_mid_stream();
    test_random_streams();

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d code words; checked %0d runs, %0d of them closing a stream.",
             words_sent, runs_checked, streams_done);
    $display("Marker register written %0d times; %0d mismatches.", marker_writes, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
